[rtl/coin_change_vending_reserve_assert.svh]
// Assertion macros, clocked on clk and disabled during arst_n.
`ifndef COIN_CHANGE_VENDING_RESERVE_ASSERT_SVH
`define COIN_CHANGE_VENDING_RESERVE_ASSERT_SVH

// Same-cycle implication.
`define CCVR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccvr check failed");

// Next-cycle implication.
`define CCVR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccvr check failed");

`endif

[rtl/ccvr_pkg.sv]
package ccvr_pkg;

	localparam int NUM_LANES = 4;
	localparam int LANE_ONE  = 0;
	localparam int LANE_TWO  = 1;
	localparam int LANE_FIVE = 2;
	localparam int LANE_TEN  = 3;

	localparam int COUNT_W = 6;
	localparam int PRICE_W = 10;
	localparam int PAY_W   = 11;
	localparam int LEVEL_W = 8;
	localparam int GIVE_W  = 7;
	localparam int EXTRA_W = 9;
	localparam int OVF_W   = 16;
	localparam int ADDED_W = 8;
	localparam int INDEX_W = 3;

	localparam logic [PRICE_W-1:0] PRICE_A_RST  = 10'd20;
	localparam logic [PRICE_W-1:0] PRICE_B_RST  = 10'd30;
	localparam logic [PRICE_W-1:0] PRICE_C_RST  = 10'd40;
	localparam logic [PRICE_W-1:0] PRICE_D_RST  = 10'd50;
	localparam logic [LEVEL_W-1:0] CAPACITY_RST = 8'd125;
	localparam logic [LEVEL_W-1:0] LEVEL_RST    = 8'd100;
	localparam logic [OVF_W-1:0]   OVF_MAX      = 16'hFFFF;
	localparam logic [ADDED_W-1:0] ADDED_MAX    = 8'hFF;

	// divide by ten: (x * 6554) >> 16, exact for x below 16384
	localparam logic [12:0] RECIP_TEN   = 13'd6554;
	localparam int          RECIP_SHIFT = 16;

	typedef enum logic [2:0] {
		ST_EXACT          = 3'd0,
		ST_CHANGE         = 3'd1,
		ST_UNDERPAID      = 3'd2,
		ST_NO_CHANGE      = 3'd3,
		ST_OUT_OF_SERVICE = 3'd4
	} sale_status_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_PRICE_A  = 3'd0,
		REG_PRICE_B  = 3'd1,
		REG_PRICE_C  = 3'd2,
		REG_PRICE_D  = 3'd3,
		REG_CAPACITY = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic               underpaid;
		logic [PAY_W-1:0]   change;
		logic [GIVE_W-1:0]  give_ten;
		logic               give_five;
		logic [1:0]         give_two;
		logic               give_one;
	} quote_t;

	typedef struct packed {
		logic               empty;
		logic               short_of;
		logic [LEVEL_W-1:0] level;
		logic [EXTRA_W-1:0] extra;
	} lane_res_t;

endpackage

[rtl/coin_change_vending_reserve.sv]
// Coin unit of a vending machine: one item is one sale.
// Input channel in_valid/in_stall carries product_choice and the counts of
// inserted 1, 2, 5 and 10 unit coins. Output channel out_valid/out_stall
// returns one result per item: sale_status, change split greedily into
// coins, the four coin reserves after the sale and the coins sent to
// overflow. Prices and reserve capacity are set through cfg_we/cfg_index/
// cfg_data, by the user only while no item is in flight; the block itself
// does not enforce this. An accepted item is registered in stage one and
// then in the output register, which raises out_valid. Stage one works
// out payment, change and the coin split; stage two runs four reserve lanes
// in parallel against the stored reserves, merges their results and commits.
// Throughput is one item per cycle without out_stall; the reserve update
// sits in stage two alone, so consecutive items never wait on each other.
// Reset loads prices 20/30/40/50, capacity 125, reserves of 100 coins and
// clears overflow counters and both pipeline stages.
// When out_stall holds, the result stays in the output register and one
// more item can be taken into stage one; then in_stall rises.
module coin_change_vending_reserve (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ccvr_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [ccvr_pkg::PRICE_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    product_choice,
	input  logic [ccvr_pkg::COUNT_W-1:0]  coins_one_in,
	input  logic [ccvr_pkg::COUNT_W-1:0]  coins_two_in,
	input  logic [ccvr_pkg::COUNT_W-1:0]  coins_five_in,
	input  logic [ccvr_pkg::COUNT_W-1:0]  coins_ten_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    sale_status,
	output logic [ccvr_pkg::PAY_W-1:0]    change_value,
	output logic [ccvr_pkg::GIVE_W-1:0]   give_ten,
	output logic                          give_five,
	output logic [1:0]                    give_two,
	output logic                          give_one,
	output logic [ccvr_pkg::LEVEL_W-1:0]  level_one,
	output logic [ccvr_pkg::LEVEL_W-1:0]  level_two,
	output logic [ccvr_pkg::LEVEL_W-1:0]  level_five,
	output logic [ccvr_pkg::LEVEL_W-1:0]  level_ten,
	output logic [ccvr_pkg::ADDED_W-1:0]  overflow_added
);
	import ccvr_pkg::*;

	`include "coin_change_vending_reserve_assert.svh"

	logic [PRICE_W-1:0] price_q [NUM_LANES];
	logic [LEVEL_W-1:0] capacity_q;

	quote_t             quote, quote_s1;
	logic               valid_s1;
	logic [COUNT_W-1:0] ins_s1 [NUM_LANES];
	logic               adv, take, commit, any_empty, any_short;
	sale_status_t       status;
	logic [GIVE_W-1:0]  lane_give [NUM_LANES];
	lane_res_t          lane_res [NUM_LANES];
	logic [PAY_W-1:0]   added_sum;
	logic [ADDED_W-1:0] added;

	logic               out_valid_q;
	sale_status_t       status_q;
	logic [PAY_W-1:0]   change_q;
	logic [GIVE_W-1:0]  give_ten_q;
	logic               give_five_q, give_one_q;
	logic [1:0]         give_two_q;
	logic [LEVEL_W-1:0] level_q [NUM_LANES];
	logic [ADDED_W-1:0] added_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_q[LANE_ONE]  <= PRICE_A_RST;
			price_q[LANE_TWO]  <= PRICE_B_RST;
			price_q[LANE_FIVE] <= PRICE_C_RST;
			price_q[LANE_TEN]  <= PRICE_D_RST;
			capacity_q         <= CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRICE_A:  price_q[0] <= cfg_data;
				REG_PRICE_B:  price_q[1] <= cfg_data;
				REG_PRICE_C:  price_q[2] <= cfg_data;
				REG_PRICE_D:  price_q[3] <= cfg_data;
				REG_CAPACITY: capacity_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage one: payment and greedy split
	ccvr_front u_front (
		.coins_one_in       (coins_one_in),
		.coins_two_in       (coins_two_in),
		.coins_five_in      (coins_five_in),
		.coins_ten_in       (coins_ten_in),
		.price              (price_q[product_choice]),
		.quote              (quote)
	);

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			quote_s1          <= quote;
			ins_s1[LANE_ONE]  <= coins_one_in;
			ins_s1[LANE_TWO]  <= coins_two_in;
			ins_s1[LANE_FIVE] <= coins_five_in;
			ins_s1[LANE_TEN]  <= coins_ten_in;
		end
	end

	// stage two: reserve lanes
	assign lane_give[LANE_ONE]  = GIVE_W'(quote_s1.give_one);
	assign lane_give[LANE_TWO]  = GIVE_W'(quote_s1.give_two);
	assign lane_give[LANE_FIVE] = GIVE_W'(quote_s1.give_five);
	assign lane_give[LANE_TEN]  = quote_s1.give_ten;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ccvr_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ins      (ins_s1[g]),
			.give     (lane_give[g]),
			.capacity (capacity_q),
			.commit   (commit),
			.res      (lane_res[g])
		);
	end

	// merge
	always_comb begin
		any_empty = 1'b0;
		any_short = 1'b0;
		added_sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			any_empty = any_empty | lane_res[i].empty;
			any_short = any_short | lane_res[i].short_of;
			added_sum = added_sum + PAY_W'(lane_res[i].extra);
		end
		if (any_empty) begin
			status = ST_OUT_OF_SERVICE;
		end else if (quote_s1.underpaid) begin
			status = ST_UNDERPAID;
		end else if (any_short) begin
			status = ST_NO_CHANGE;
		end else if (quote_s1.change == '0) begin
			status = ST_EXACT;
		end else begin
			status = ST_CHANGE;
		end
		added = (added_sum > PAY_W'(ADDED_MAX)) ? ADDED_MAX : added_sum[ADDED_W-1:0];
	end

	assign commit = adv && valid_s1 && (status == ST_EXACT || status == ST_CHANGE);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			status_q <= status;
			for (int i = 0; i < NUM_LANES; i++) begin
				level_q[i] <= lane_res[i].level;
			end
			if (status == ST_EXACT || status == ST_CHANGE) begin
				change_q    <= quote_s1.change;
				give_ten_q  <= quote_s1.give_ten;
				give_five_q <= quote_s1.give_five;
				give_two_q  <= quote_s1.give_two;
				give_one_q  <= quote_s1.give_one;
				added_q     <= added;
			end else begin
				change_q    <= '0;
				give_ten_q  <= '0;
				give_five_q <= 1'b0;
				give_two_q  <= '0;
				give_one_q  <= 1'b0;
				added_q     <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign sale_status    = status_q;
	assign change_value   = change_q;
	assign give_ten       = give_ten_q;
	assign give_five      = give_five_q;
	assign give_two       = give_two_q;
	assign give_one       = give_one_q;
	assign level_one      = level_q[LANE_ONE];
	assign level_two      = level_q[LANE_TWO];
	assign level_five     = level_q[LANE_FIVE];
	assign level_ten      = level_q[LANE_TEN];
	assign overflow_added = added_q;

	`CCVR_ASSERT_IMP(a_refused_zero,
		out_valid_q && !(status_q == ST_EXACT || status_q == ST_CHANGE),
		change_q == '0 && give_ten_q == '0 && !give_five_q && give_two_q == '0
		&& !give_one_q && added_q == '0)
	`CCVR_ASSERT_IMP(a_change_sum, out_valid_q,
		change_q == PAY_W'(give_ten_q) * 11'd10 + PAY_W'(give_five_q) * 11'd5
		+ PAY_W'(give_two_q) * 11'd2 + PAY_W'(give_one_q))
	`CCVR_ASSERT_IMP(a_exact_code,
		out_valid_q && (status_q == ST_EXACT || status_q == ST_CHANGE),
		(status_q == ST_EXACT) == (change_q == '0))
	`CCVR_ASSERT_NXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(quote_s1))

endmodule

[rtl/ccvr_front.sv]
module ccvr_front (
	input  logic [ccvr_pkg::COUNT_W-1:0] coins_one_in,
	input  logic [ccvr_pkg::COUNT_W-1:0] coins_two_in,
	input  logic [ccvr_pkg::COUNT_W-1:0] coins_five_in,
	input  logic [ccvr_pkg::COUNT_W-1:0] coins_ten_in,
	input  logic [ccvr_pkg::PRICE_W-1:0] price,
	output ccvr_pkg::quote_t             quote
);
	import ccvr_pkg::*;

	logic [PAY_W-1:0]    w_one, w_two, w_five, w_ten, pay, change, tens_val;
	logic [23:0]         prod;
	logic [GIVE_W-1:0]   q_ten;
	logic [3:0]          rem;
	logic                five;
	logic [2:0]          r2;

	assign w_one  = PAY_W'(coins_one_in);
	assign w_two  = PAY_W'({coins_two_in, 1'b0});
	assign w_five = PAY_W'({coins_five_in, 2'b00}) + PAY_W'(coins_five_in);
	assign w_ten  = PAY_W'({coins_ten_in, 3'b000}) + PAY_W'({coins_ten_in, 1'b0});
	assign pay    = w_one + w_two + w_five + w_ten;
	assign change = pay - PAY_W'(price);

	assign prod     = 24'(change) * 24'(RECIP_TEN);
	assign q_ten    = prod[RECIP_SHIFT +: GIVE_W];
	assign tens_val = PAY_W'({q_ten, 3'b000}) + PAY_W'({q_ten, 1'b0});
	assign rem      = 4'(change - tens_val);
	assign five     = (rem >= 4'd5);
	assign r2       = five ? 3'(rem - 4'd5) : rem[2:0];

	always_comb begin
		quote.underpaid = (pay < PAY_W'(price));
		quote.change    = change;
		quote.give_ten  = q_ten;
		quote.give_five = five;
		quote.give_two  = r2[2:1];
		quote.give_one  = r2[0];
	end

endmodule

[rtl/ccvr_lane.sv]
module ccvr_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ccvr_pkg::COUNT_W-1:0]  ins,
	input  logic [ccvr_pkg::GIVE_W-1:0]   give,
	input  logic [ccvr_pkg::LEVEL_W-1:0]  capacity,
	input  logic                          commit,
	output ccvr_pkg::lane_res_t           res
);
	import ccvr_pkg::*;

	logic [LEVEL_W-1:0] level_q, new_level;
	logic [OVF_W-1:0]   ovf_q, ovf_next;
	logic [EXTRA_W-1:0] total, lvl, extra;
	logic [OVF_W:0]     ovf_sum;
	logic               over;

	assign total     = EXTRA_W'(level_q) + EXTRA_W'(ins);
	assign lvl       = total - EXTRA_W'(give);
	assign over      = lvl > EXTRA_W'(capacity);
	assign extra     = over ? (lvl - EXTRA_W'(capacity)) : '0;
	assign new_level = over ? capacity : lvl[LEVEL_W-1:0];
	assign ovf_sum   = (OVF_W+1)'(ovf_q) + (OVF_W+1)'(extra);
	assign ovf_next  = ovf_sum[OVF_W] ? OVF_MAX : ovf_sum[OVF_W-1:0];

	always_comb begin
		res.empty    = (level_q == '0);
		res.short_of = (total < EXTRA_W'(give));
		res.level    = commit ? new_level : level_q;
		res.extra    = extra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RST;
			ovf_q   <= '0;
		end else if (commit) begin
			level_q <= new_level;
			ovf_q   <= ovf_next;
		end
	end

endmodule
